// ----- rtl/pte_pkg.sv -----
// ----------------------------------------------------------------------------
// pte_pkg
// shared types, codes and field helpers for the pixel to rgb888 expander
// ----------------------------------------------------------------------------
package pte_pkg;

  // palette geometry
  localparam int PAL_ENTRIES = 256;
  localparam int PAL_IDX_W   = $clog2(PAL_ENTRIES);
  localparam int PAL_CNT_W   = 9;

  // field widths
  localparam int PIX_W = 32;
  localparam int COL_W = 8;
  localparam int CFG_W = 9;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_PIXEL_FORMAT  = 1'b0,
    REG_PALETTE_COUNT = 1'b1
  } cfg_reg_t;

  // input beat commands
  typedef enum logic [0:0] {
    CMD_CONVERT   = 1'b0,
    CMD_PAL_WRITE = 1'b1
  } cmd_t;

  // pixel format codes, values 6 and 7 behave like the direct modes
  localparam logic [2:0] FMT_4BPP   = 3'd0;
  localparam logic [2:0] FMT_8BPP   = 3'd1;
  localparam logic [2:0] FMT_15BPP  = 3'd2;
  localparam logic [2:0] FMT_16BPP  = 3'd3;
  localparam logic [2:0] FMT_24BPP  = 3'd4;
  localparam logic [2:0] FMT_32BPP  = 3'd5;

  // one converted color plus the lookup error flag
  typedef struct packed {
    logic [COL_W-1:0] red;
    logic [COL_W-1:0] green;
    logic [COL_W-1:0] blue;
    logic             index_error;
  } rgb_res_t;

  // 5-bit field to 8 bits, low bits copied from the field's lowest bit
  function automatic logic [COL_W-1:0] expand5(input logic [4:0] f);
    expand5 = {f, {3{f[0]}}};
  endfunction

  // 6-bit field to 8 bits, low bits copied from the field's lowest bit
  function automatic logic [COL_W-1:0] expand6(input logic [5:0] f);
    expand6 = {f, {2{f[0]}}};
  endfunction

endpackage

// ----- rtl/pte_in_if.sv -----
// ----------------------------------------------------------------------------
// pte_in_if
// input channel: pixel convert and palette write beats
// ----------------------------------------------------------------------------
interface pte_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [31:0] pixel_word;
  logic [7:0]  entry_index;
  logic [7:0]  entry_red;
  logic [7:0]  entry_green;
  logic [7:0]  entry_blue;

  modport source (
    output valid, cmd, pixel_word, entry_index, entry_red, entry_green, entry_blue,
    input  ready
  );

  modport sink (
    input  valid, cmd, pixel_word, entry_index, entry_red, entry_green, entry_blue,
    output ready
  );
endinterface

// ----- rtl/pte_out_if.sv -----
// ----------------------------------------------------------------------------
// pte_out_if
// result channel: expanded rgb888 color beats
// ----------------------------------------------------------------------------
interface pte_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [31:0] pixel_echo;
  logic        index_error;

  modport source (
    output valid, red, green, blue, pixel_echo, index_error,
    input  ready
  );

  modport sink (
    input  valid, red, green, blue, pixel_echo, index_error,
    output ready
  );
endinterface

// ----- rtl/pixel_to_rgb888_expander.sv -----
// ----------------------------------------------------------------------------
// pixel_to_rgb888_expander
// raw pixel word to 8-bit red, green and blue in the configured format
// ----------------------------------------------------------------------------
// usage:
//   in_ch carries beats of two kinds. a convert beat (cmd 0) yields exactly
//   one result beat on out_ch; a palette write beat (cmd 1) loads one
//   palette entry and yields nothing.
//   cfg_we/cfg_index/cfg_data set pixel_format (index 0) and palette_count
//   (index 1); write them only while no beat is in flight.
// pipeline and throughput:
//   a convert beat passes the read stage, which reads the 256-entry palette
//   ram into its registered read port, and then the format decode into the
//   result register that drives out_ch.
//   one beat per cycle is taken sustained while out_ch.ready stays high; the
//   single palette ram port pair (one write, one read per cycle) sets that figure.
// reset:
//   pipeline empties, pixel_format goes to 32 bpp, palette_count to 0;
//   palette contents are undefined until written.
// stall:
//   while out_ch.ready is low the result holds, one more beat may sit in
//   the read stage, and in_ch.ready drops once both are full.
// ----------------------------------------------------------------------------
module pixel_to_rgb888_expander (
  input  logic                          clk,
  input  logic                          rst_n,
  pte_in_if.sink                        in_ch,
  pte_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [0:0]                    cfg_index,
  input  logic [pte_pkg::CFG_W-1:0]     cfg_data
);
  import pte_pkg::*;

  // configuration
  logic [2:0]             fmt_r;
  logic [PAL_CNT_W-1:0]   pal_count_r;

  // palette ram
  logic [3*COL_W-1:0]     pal_mem [PAL_ENTRIES];
  logic [3*COL_W-1:0]     rd_data_r;

  // read stage
  logic                   s1_v_r;
  logic                   s1_v_nxt;
  logic [PIX_W-1:0]       s1_pix_r;

  // result stage
  logic                   out_v_r;
  logic                   out_v_nxt;
  logic [PIX_W-1:0]       out_pix_r;
  rgb_res_t               out_res_r;
  rgb_res_t               conv_res;

  logic                   in_acc;
  logic                   out_load;
  logic                   pal_wr;

  // handshake
  assign out_load     = !out_v_r || out_ch.ready;
  assign in_ch.ready  = !s1_v_r || out_load;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign pal_wr       = in_acc && (in_ch.cmd == CMD_PAL_WRITE) &&
                        (PAL_CNT_W'(in_ch.entry_index) < PAL_CNT_W'(PAL_ENTRIES));

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r       <= FMT_32BPP;
      pal_count_r <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_PIXEL_FORMAT:  fmt_r       <= cfg_data[2:0];
        REG_PALETTE_COUNT: pal_count_r <= cfg_data[PAL_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // palette ram, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (pal_wr) begin
      pal_mem[in_ch.entry_index[PAL_IDX_W-1:0]] <=
        {in_ch.entry_blue, in_ch.entry_green, in_ch.entry_red};
    end
    if (in_acc) begin
      rd_data_r <= pal_mem[in_ch.pixel_word[PAL_IDX_W-1:0]];
    end
  end

  // read stage valid: only convert beats travel on
  always_comb begin
    s1_v_nxt = s1_v_r && !out_load;
    if (in_acc) begin
      s1_v_nxt = (in_ch.cmd == CMD_CONVERT);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix_r <= in_ch.pixel_word;
    end
  end

  // format decode
  pte_convert u_convert (
    .fmt       (fmt_r),
    .pixel     (s1_pix_r),
    .pal_count (pal_count_r),
    .pal_entry (rd_data_r),
    .res       (conv_res)
  );

  // result register
  assign out_v_nxt = out_load ? s1_v_r : out_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && s1_v_r) begin
      out_res_r <= conv_res;
      out_pix_r <= s1_pix_r;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.red         = out_res_r.red;
  assign out_ch.green       = out_res_r.green;
  assign out_ch.blue        = out_res_r.blue;
  assign out_ch.pixel_echo  = out_pix_r;
  assign out_ch.index_error = out_res_r.index_error;

  // palette writes never occupy the read stage
  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_ch.cmd == CMD_PAL_WRITE) |=> !s1_v_r)
    else $error("palette write beat entered the read stage");

  // a waiting beat in the read stage is kept while the result stalls
  a_s1_kept: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && out_v_r && !out_ch.ready |=> s1_v_r)
    else $error("read stage beat lost during stall");

  // lookup errors only come from indexed formats
  a_err_indexed: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_res_r.index_error |-> (fmt_r == FMT_4BPP || fmt_r == FMT_8BPP))
    else $error("index error in a direct format");

  // every convert beat leaving the read stage shows up as a result in the cycle after
  a_s1_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && out_load |=> out_v_r)
    else $error("read stage beat did not reach the result register");

endmodule

// ----- rtl/pte_convert.sv -----
// ----------------------------------------------------------------------------
// pte_convert
// format decode: field expansion, byte pick or palette lookup check
// ----------------------------------------------------------------------------
module pte_convert (
  input  logic [2:0]                     fmt,
  input  logic [pte_pkg::PIX_W-1:0]      pixel,
  input  logic [pte_pkg::PAL_CNT_W-1:0]  pal_count,
  input  logic [3*pte_pkg::COL_W-1:0]    pal_entry,
  output pte_pkg::rgb_res_t              res
);
  import pte_pkg::*;

  logic                 hi_zero;
  logic [PAL_CNT_W-1:0] cnt_sat;
  logic                 idx_ok;

  // index is valid when below the count, count clipped to the palette size
  assign hi_zero = (pixel[PIX_W-1:PAL_IDX_W] == '0);
  assign cnt_sat = (pal_count > PAL_CNT_W'(PAL_ENTRIES)) ? PAL_CNT_W'(PAL_ENTRIES)
                                                         : pal_count;
  assign idx_ok  = hi_zero && (PAL_CNT_W'(pixel[PAL_IDX_W-1:0]) < cnt_sat);

  // per-format color
  always_comb begin
    res = '0;
    case (fmt)
      FMT_4BPP, FMT_8BPP: begin
        if (idx_ok) begin
          res.red   = pal_entry[COL_W-1:0];
          res.green = pal_entry[2*COL_W-1:COL_W];
          res.blue  = pal_entry[3*COL_W-1:2*COL_W];
        end else begin
          res.index_error = 1'b1;
        end
      end
      FMT_15BPP: begin
        res.red   = expand5(pixel[14:10]);
        res.green = expand5(pixel[9:5]);
        res.blue  = expand5(pixel[4:0]);
      end
      FMT_16BPP: begin
        res.red   = expand5(pixel[15:11]);
        res.green = expand6(pixel[10:5]);
        res.blue  = expand5(pixel[4:0]);
      end
      default: begin
        res.red   = pixel[7:0];
        res.green = pixel[15:8];
        res.blue  = pixel[23:16];
      end
    endcase
  end

endmodule

// ----- verif/pixel_to_rgb888_expander_checker.sv -----
// ----------------------------------------------------------------------------
// pixel_to_rgb888_expander_checker
// watches the input, result and register ports of the expander, predicts
// each converted color from its own copy of the format, palette count and
// palette, and compares every result beat field by field in order
// ----------------------------------------------------------------------------
module pixel_to_rgb888_expander_checker
  import pte_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  pte_in_if                in_ch,
  pte_out_if               out_ch,
  input  logic             cfg_we,
  input  logic [0:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  output int               fail_count,
  output int               results_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  // one predicted result beat
  typedef struct packed {
    logic [COL_W-1:0] red;
    logic [COL_W-1:0] green;
    logic [COL_W-1:0] blue;
    logic [PIX_W-1:0] pixel_echo;
    logic             index_error;
  } color_beat_t;

  // shadow of the block's registers and palette, entries packed blue/green/red
  logic [2:0]           fmt_q;
  logic [PAL_CNT_W-1:0] count_q;
  logic [23:0]          pal_mem [PAL_ENTRIES];

  color_beat_t pending_colors [$];

  // field already at the top of its byte; copy bit 'low' into the bits below
  function automatic logic [COL_W-1:0] copy_down(input logic [COL_W-1:0] v, input int low);
    logic [COL_W-1:0] r;
    r = v;
    for (int k = 0; k < low; k++) r[k] = v[low];
    return r;
  endfunction

  // expected color for one convert beat under the current shadow state
  function automatic color_beat_t expand_pixel(input logic [PIX_W-1:0] pix);
    color_beat_t c;
    int unsigned lim;
    c = '0;
    c.pixel_echo = pix;
    case (fmt_q)
      FMT_4BPP, FMT_8BPP: begin
        // palette count saturates at the store depth
        lim = (count_q > PAL_CNT_W'(PAL_ENTRIES)) ? PAL_ENTRIES : 32'(count_q);
        if (pix < lim) begin
          c.red   = pal_mem[pix[PAL_IDX_W-1:0]][7:0];
          c.green = pal_mem[pix[PAL_IDX_W-1:0]][15:8];
          c.blue  = pal_mem[pix[PAL_IDX_W-1:0]][23:16];
        end else begin
          c.index_error = 1'b1;
        end
      end
      FMT_15BPP: begin
        c.red   = copy_down({pix[14:10], 3'b000}, 3);
        c.green = copy_down({pix[9:5], 3'b000}, 3);
        c.blue  = copy_down({pix[4:0], 3'b000}, 3);
      end
      FMT_16BPP: begin
        c.red   = copy_down({pix[15:11], 3'b000}, 3);
        c.green = copy_down({pix[10:5], 2'b00}, 2);
        c.blue  = copy_down({pix[4:0], 3'b000}, 3);
      end
      // direct modes, spare codes included
      default: begin
        c.red   = pix[7:0];
        c.green = pix[15:8];
        c.blue  = pix[23:16];
      end
    endcase
    return c;
  endfunction

  task automatic compare_field(input string field, input logic [PIX_W-1:0] want,
                               input logic [PIX_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
      fail_count++;
    end
  endtask

  // track registers and palette, predict on each convert beat, check results
  always @(posedge clk) begin
    color_beat_t want;
    if (!rst_n) begin
      fmt_q        = FMT_32BPP;
      count_q      = '0;
      fail_count   = 0;
      pending_colors.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_PIXEL_FORMAT:  fmt_q   = cfg_data[2:0];
          REG_PALETTE_COUNT: count_q = cfg_data[PAL_CNT_W-1:0];
          default: ;
        endcase
      end

      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.cmd == CMD_PAL_WRITE)
          pal_mem[in_ch.entry_index] = {in_ch.entry_blue, in_ch.entry_green, in_ch.entry_red};
        else
          pending_colors.push_back(expand_pixel(in_ch.pixel_word));
      end

      if (out_ch.valid && out_ch.ready) begin
        if (pending_colors.size() == 0) begin
          $error("result beat with no pixel pending: pixel_echo 0x%0h", out_ch.pixel_echo);
          fail_count++;
        end else begin
          want = pending_colors.pop_front();
          compare_field("red", PIX_W'(want.red), PIX_W'(out_ch.red));
          compare_field("green", PIX_W'(want.green), PIX_W'(out_ch.green));
          compare_field("blue", PIX_W'(want.blue), PIX_W'(out_ch.blue));
          compare_field("pixel_echo", want.pixel_echo, out_ch.pixel_echo);
          compare_field("index_error", PIX_W'(want.index_error),
                        PIX_W'(out_ch.index_error));
        end
      end
    end
    results_owed = pending_colors.size();
  end

endmodule

// ----- verif/pixel_to_rgb888_expander_test.sv -----
// ----------------------------------------------------------------------------
// pixel_to_rgb888_expander_test
// drives convert and palette write beats through every pixel format and a
// range of palette counts, with random idling on both channels and one long
// output stall; the checker beside the block predicts and compares
// ----------------------------------------------------------------------------
module pixel_to_rgb888_expander_test;
  timeunit 1ns;
  timeprecision 1ps;
  import pte_pkg::*;

  // spare format codes, decoded like the direct modes
  localparam logic [2:0] FMT_SPARE6 = 3'd6;
  localparam logic [2:0] FMT_SPARE7 = 3'd7;

  localparam int SETTLE_CYCLES = 6;
  localparam int LONG_STALL    = 60;
  localparam int PHASE_BEATS   = 42;
  localparam int NUM_PHASES    = 13;

  localparam logic [2:0] PHASE_FMT [NUM_PHASES] = '{
    FMT_8BPP, FMT_16BPP, FMT_4BPP, FMT_15BPP, FMT_32BPP, FMT_8BPP, FMT_24BPP,
    FMT_4BPP, FMT_SPARE6, FMT_8BPP, FMT_SPARE7, FMT_4BPP, FMT_16BPP
  };
  localparam int PHASE_COUNT [NUM_PHASES] = '{
    256, 0, 16, 511, 128, 511, 256, 1, 3, 0, 64, 200, 255
  };

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [0:0]       cfg_index;
  logic [CFG_W-1:0] cfg_data;
  int               fail_count;
  int               results_owed;

  pte_in_if  in_ch ();
  pte_out_if out_ch ();

  // stimulus-side view of the block, used to keep lookups on written entries
  logic [2:0]           cur_fmt;
  logic [PAL_CNT_W-1:0] cur_count;
  bit                   written [PAL_ENTRIES];
  bit                   steady;
  bit                   hold_output;

  pixel_to_rgb888_expander u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pixel_to_rgb888_expander_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .results_owed (results_owed)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  initial begin
    #100_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    int stall_left;
    bit stall_done;
    stall_left = 0;
    stall_done = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_output && !stall_done) begin
        stall_left = LONG_STALL;
        stall_done = 1;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= steady || ($urandom_range(99) >= 8);
      end
    end
  end

  // offer one beat and wait for it to be taken; valid stays high on return
  task automatic send_beat(input cmd_t cmd, input logic [PIX_W-1:0] pix,
                           input logic [7:0] idx, input logic [7:0] r,
                           input logic [7:0] g, input logic [7:0] b);
    if (!steady && $urandom_range(99) < 8) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.cmd         <= cmd;
    in_ch.pixel_word  <= pix;
    in_ch.entry_index <= idx;
    in_ch.entry_red   <= r;
    in_ch.entry_green <= g;
    in_ch.entry_blue  <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic write_entry(input logic [7:0] idx, input logic [7:0] r,
                             input logic [7:0] g, input logic [7:0] b);
    send_beat(CMD_PAL_WRITE, $urandom(), idx, r, g, b);
    written[idx] = 1'b1;
  endtask

  // convert beat; a lookup of a never-written entry gets that entry loaded first
  task automatic send_pixel(input logic [PIX_W-1:0] pix);
    int unsigned lim;
    lim = (cur_count > PAL_CNT_W'(PAL_ENTRIES)) ? PAL_ENTRIES : 32'(cur_count);
    if ((cur_fmt == FMT_4BPP || cur_fmt == FMT_8BPP) && pix < lim && !written[pix[7:0]])
      write_entry(pix[7:0], 8'($urandom()), 8'($urandom()), 8'($urandom()));
    send_beat(CMD_CONVERT, pix, 8'($urandom()), 8'($urandom()), 8'($urandom()),
              8'($urandom()));
  endtask

  // drain the block, then write both registers
  task automatic configure(input logic [2:0] fmt, input logic [PAL_CNT_W-1:0] count);
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_PIXEL_FORMAT;
    cfg_data  <= CFG_W'(fmt);
    @(posedge clk);
    cfg_index <= REG_PALETTE_COUNT;
    cfg_data  <= CFG_W'(count);
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_fmt   = fmt;
    cur_count = count;
  endtask

  // stimulus and verdict
  initial begin
    int          pick;
    int unsigned lim;
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= REG_PIXEL_FORMAT;
    cfg_data          <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.cmd         <= CMD_CONVERT;
    in_ch.pixel_word  <= '0;
    in_ch.entry_index <= '0;
    in_ch.entry_red   <= '0;
    in_ch.entry_green <= '0;
    in_ch.entry_blue  <= '0;
    cur_fmt     = FMT_32BPP;
    cur_count   = '0;
    steady      = 0;
    hold_output = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // direct mode straight out of reset
    send_pixel(32'h0000_0000);
    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'h3C5A_A5C3);

    // 555: full fields, upper junk only, lowest bits set, lowest bits clear
    configure(FMT_15BPP, '0);
    send_pixel(32'h0000_7FFF);
    send_pixel(32'hFFFF_8000);
    send_pixel(32'h0000_0421);
    send_pixel(32'h0000_7BDE);

    // 565: same idea with the 6-bit green field
    configure(FMT_16BPP, '0);
    send_pixel(32'h0000_FFFF);
    send_pixel(32'hFFFF_0821);
    send_pixel(32'h0000_F7DE);

    // palette ends, then lookups at both ends and past the count
    write_entry(8'h00, 8'hFF, 8'h00, 8'h81);
    write_entry(8'hFF, 8'h00, 8'hFF, 8'h7E);
    configure(FMT_8BPP, 9'd256);
    send_pixel(32'd0);
    send_pixel(32'd255);
    send_pixel(32'd256);
    send_pixel(32'hFFFF_FFFF);

    // empty palette, then a count past the store depth that saturates
    configure(FMT_4BPP, 9'd0);
    send_pixel(32'd0);
    configure(FMT_4BPP, 9'd511);
    send_pixel(32'd255);
    send_pixel(32'd256);

    // spare format codes
    configure(FMT_SPARE6, 9'd0);
    send_pixel(32'h1234_5678);
    configure(FMT_SPARE7, 9'd0);
    send_pixel(32'h89AB_CDEF);

    // random phases over formats and counts
    for (int p = 0; p < NUM_PHASES; p++) begin
      configure(PHASE_FMT[p], PAL_CNT_W'(PHASE_COUNT[p]));
      hold_output = (p == 1);
      steady      = (p == 4);
      lim = (cur_count > PAL_CNT_W'(PAL_ENTRIES)) ? PAL_ENTRIES : 32'(cur_count);
      for (int i = 0; i < PHASE_BEATS; i++) begin
        pick = $urandom_range(99);
        if (pick < 20)
          write_entry(8'($urandom()), 8'($urandom()), 8'($urandom()), 8'($urandom()));
        else if (cur_fmt != FMT_4BPP && cur_fmt != FMT_8BPP)
          send_pixel($urandom());
        else if (pick < 75 && lim > 0)
          send_pixel($urandom_range(lim - 1));
        else if (pick < 90)
          send_pixel(lim + $urandom_range(3));
        else
          send_pixel($urandom());
      end
    end
    steady = 0;

    // drain and give the verdict
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && results_owed == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/pte_pkg.sv
rtl/pte_in_if.sv
rtl/pte_out_if.sv
rtl/pte_convert.sv
rtl/pixel_to_rgb888_expander.sv
verif/pixel_to_rgb888_expander_checker.sv
verif/pixel_to_rgb888_expander_test.sv
